### hdl/four_square_decipher_core_assert.svh
// assertion helpers for the four-square decipher core
`ifndef FOUR_SQUARE_DECIPHER_CORE_ASSERT_SVH
`define FOUR_SQUARE_DECIPHER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FSD_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("four-square decipher check failed");
`define FSD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("four-square decipher check failed");
`else
`define FSD_ASSERT(label, prop)
`define FSD_ASSERT_IMPL(label, ante, cons)
`endif
`endif

### hdl/fsd_pkg.sv
package fsd_pkg;

    localparam int LETTER_W = 8;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;
    localparam int LETTERS  = 26;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [LETTERS-1:0]  t_seen;

    // input word kinds
    localparam t_kind KIND_CLEAR   = 3'd0;
    localparam t_kind KIND_KEY_ONE = 3'd1;
    localparam t_kind KIND_KEY_TWO = 3'd2;
    localparam t_kind KIND_SEAL    = 3'd3;
    localparam t_kind KIND_PAIR    = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ABSENT   = 2'd1,
        STATUS_UNSEALED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SEAL = 3'b100
    } t_state;

    localparam t_letter CHAR_A       = 8'h41;
    localparam t_letter CHAR_Z       = 8'h5A;
    localparam t_pos    J_INDEX      = 5'd9;
    localparam t_pos    CELLS_POS    = 5'd25;
    localparam t_pos    LAST_CELL    = 5'd24;
    localparam t_pos    LETTER_COUNT = 5'd26;

    // cell of the plain square to letter index in A..Z, skipping J
    function automatic t_pos cell_to_letter(input t_pos slot);
        return (slot < J_INDEX) ? slot : slot + 5'd1;
    endfunction

    function automatic t_letter plain_char(input t_pos slot);
        return CHAR_A + {3'b000, cell_to_letter(slot)};
    endfunction

    // divide by five through a reciprocal, exact for 0..31
    function automatic logic [2:0] pos_row(input t_pos p);
        logic [8:0] prod;
        prod = {4'b0000, p} * 9'd13;
        return prod[8:6];
    endfunction

    function automatic logic [2:0] pos_col(input t_pos p);
        logic [4:0] base;
        logic [4:0] diff;
        base = {2'b00, pos_row(p)} * 5'd5;
        diff = p - base;
        return diff[2:0];
    endfunction

    function automatic t_pos cell_index(input logic [2:0] row, input logic [2:0] col);
        return {2'b00, row} * 5'd5 + {2'b00, col};
    endfunction

endpackage

### hdl/fsd_in_if.sv
interface fsd_in_if;
    import fsd_pkg::*;

    logic    valid;
    logic    ready;
    t_kind   kind;
    t_letter letter_a;
    t_letter letter_b;

    modport source (output valid, kind, letter_a, letter_b, input ready);
    modport sink   (input valid, kind, letter_a, letter_b, output ready);
endinterface

### hdl/fsd_out_if.sv
interface fsd_out_if;
    import fsd_pkg::*;

    logic                valid;
    logic                ready;
    t_letter             plain_first;
    t_letter             plain_second;
    logic [STATUS_W-1:0] status;

    modport source (output valid, plain_first, plain_second, status, input ready);
    modport sink   (input valid, plain_first, plain_second, status, output ready);
endinterface

### hdl/four_square_decipher_core.sv
// Four-square decipher core. Words arrive on i_in with a kind: clear empties both keyed
// squares and drops the seal; a key-one or key-two word adds an uppercase letter to
// its square at the next position (repeats, other bytes and letters after sealing are
// dropped); seal fills both squares with the unused letters of the J-less alphabet;
// a pair word yields one result word on o_out with the two plaintext letters and a
// status (ok, letter not in its square, squares not sealed; letters zero unless ok).
// Only pair words produce results. Clear and key words complete in the accept cycle. For a
// pair, the letter positions are read from the two position RAMs in the accept cycle and
// the row/column swap and plain-square lookup load the output register in the read state,
// waiting there only while an earlier result is still untaken. Seal goes from the accept
// cycle through the seal state, one alphabet letter per cycle, written through each RAM's
// write port.
// Positions are tracked by per-square seen flags, so no clearing pass runs after reset.
`include "four_square_decipher_core_assert.svh"

module four_square_decipher_core (
    input  logic i_clk,
    input  logic i_rst_n,
    fsd_in_if.sink    i_in,
    fsd_out_if.source o_out
);
    import fsd_pkg::*;

    t_state  r_state;
    t_seen   r_seen_one;
    t_seen   r_seen_two;
    t_pos    r_count_one;
    t_pos    r_count_two;
    logic    r_sealed;
    t_pos    r_seal_i;
    logic    r_ok_a;
    logic    r_ok_b;

    // output register
    logic    r_out_valid;
    t_letter r_out_first;
    t_letter r_out_second;
    t_status r_out_status;

    t_letter n_first;
    t_letter n_second;
    t_status n_status;

    logic    accept;
    logic    load_out;
    logic    upper_a;
    logic    upper_b;
    t_letter idx_a;
    t_letter idx_b;
    t_pos    addr_a;
    t_pos    addr_b;

    logic    key_one;
    logic    key_two;
    t_pos    seal_letter;
    logic    seal_one;
    logic    seal_two;

    logic    we_one;
    logic    we_two;
    t_pos    waddr_one;
    t_pos    waddr_two;
    t_pos    pos_one;
    t_pos    pos_two;

    logic    hit_one;
    logic    hit_two;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // lookup result moves into the output register once it is free
    assign load_out = (r_state == S_READ) && (!r_out_valid || o_out.ready);

    // letter to table index, valid only for uppercase
    assign upper_a = (i_in.letter_a >= CHAR_A) && (i_in.letter_a <= CHAR_Z);
    assign upper_b = (i_in.letter_b >= CHAR_A) && (i_in.letter_b <= CHAR_Z);
    assign idx_a   = i_in.letter_a - CHAR_A;
    assign idx_b   = i_in.letter_b - CHAR_A;
    assign addr_a  = idx_a[POS_W-1:0];
    assign addr_b  = idx_b[POS_W-1:0];

    // new key letter goes to the next free position
    assign key_one = accept && (i_in.kind == KIND_KEY_ONE) && !r_sealed
                     && upper_a && !r_seen_one[addr_a];
    assign key_two = accept && (i_in.kind == KIND_KEY_TWO) && !r_sealed
                     && upper_a && !r_seen_two[addr_a];

    // seal walk: one plain-alphabet letter per cycle, both squares in parallel
    assign seal_letter = cell_to_letter(r_seal_i);
    assign seal_one    = (r_count_one < CELLS_POS) && !r_seen_one[seal_letter];
    assign seal_two    = (r_count_two < CELLS_POS) && !r_seen_two[seal_letter];

    // one write source per state: key words in idle, fill letters while sealing
    assign we_one    = (r_state == S_SEAL) ? seal_one : key_one;
    assign we_two    = (r_state == S_SEAL) ? seal_two : key_two;
    assign waddr_one = (r_state == S_SEAL) ? seal_letter : addr_a;
    assign waddr_two = (r_state == S_SEAL) ? seal_letter : addr_a;

    fsd_ram #(
        .WIDTH (POS_W),
        .DEPTH (LETTERS)
    ) u_pos_one (
        .i_clk   (i_clk),
        .i_we    (we_one),
        .i_waddr (waddr_one),
        .i_wdata (r_count_one),
        .i_re    (accept),
        .i_raddr (addr_a),
        .o_rdata (pos_one)
    );

    fsd_ram #(
        .WIDTH (POS_W),
        .DEPTH (LETTERS)
    ) u_pos_two (
        .i_clk   (i_clk),
        .i_we    (we_two),
        .i_waddr (waddr_two),
        .i_wdata (r_count_two),
        .i_re    (accept),
        .i_raddr (addr_b),
        .o_rdata (pos_two)
    );

    // pair lookup on the registered positions: swap columns, read the plain square
    assign hit_one = r_ok_a && (pos_one < CELLS_POS);
    assign hit_two = r_ok_b && (pos_two < CELLS_POS);

    always_comb begin
        n_first  = '0;
        n_second = '0;
        n_status = STATUS_OK;
        if (!r_sealed) begin
            n_status = STATUS_UNSEALED;
        end else if (!(hit_one && hit_two)) begin
            n_status = STATUS_ABSENT;
        end else begin
            n_first  = plain_char(cell_index(pos_row(pos_one), pos_col(pos_two)));
            n_second = plain_char(cell_index(pos_row(pos_two), pos_col(pos_one)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen_one  <= '0;
            r_seen_two  <= '0;
            r_count_one <= '0;
            r_count_two <= '0;
            r_sealed    <= 1'b0;
            r_seal_i    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_in.kind)
                            KIND_CLEAR: begin
                                r_seen_one  <= '0;
                                r_seen_two  <= '0;
                                r_count_one <= '0;
                                r_count_two <= '0;
                                r_sealed    <= 1'b0;
                            end
                            KIND_KEY_ONE: begin
                                if (key_one) begin
                                    r_seen_one[addr_a] <= 1'b1;
                                    r_count_one        <= r_count_one + 5'd1;
                                end
                            end
                            KIND_KEY_TWO: begin
                                if (key_two) begin
                                    r_seen_two[addr_a] <= 1'b1;
                                    r_count_two        <= r_count_two + 5'd1;
                                end
                            end
                            KIND_SEAL: begin
                                r_seal_i <= '0;
                                r_state  <= S_SEAL;
                            end
                            KIND_PAIR: begin
                                // seen flags checked now, positions arrive next cycle
                                r_ok_a  <= upper_a && r_seen_one[addr_a];
                                r_ok_b  <= upper_b && r_seen_two[addr_b];
                                r_state <= S_READ;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    // hold the lookup until the output register is free
                    if (load_out) begin
                        r_out_first  <= n_first;
                        r_out_second <= n_second;
                        r_out_status <= n_status;
                        r_state      <= S_IDLE;
                    end
                end
                S_SEAL: begin
                    if (seal_one) begin
                        r_seen_one[seal_letter] <= 1'b1;
                        r_count_one             <= r_count_one + 5'd1;
                    end
                    if (seal_two) begin
                        r_seen_two[seal_letter] <= 1'b1;
                        r_count_two             <= r_count_two + 5'd1;
                    end
                    if (r_seal_i == LAST_CELL) begin
                        r_sealed <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_seal_i <= r_seal_i + 5'd1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.plain_first  = r_out_first;
    assign o_out.plain_second = r_out_second;
    assign o_out.status       = r_out_status;

    // a result only ever comes out of the lookup cycle
    `FSD_ASSERT_IMPL(a_out_from_read, $rose(r_out_valid), $past(r_state == S_READ))
    // the seal flag is only set at the end of a seal walk
    `FSD_ASSERT_IMPL(a_seal_from_walk, $rose(r_sealed), $past(r_state == S_SEAL))
    // no position write may race the pending pair read
    `FSD_ASSERT_IMPL(a_no_write_in_read, r_state == S_READ, !(we_one || we_two))
    // a square never holds more positions than letters
    `FSD_ASSERT(a_count_bound, (r_count_one <= LETTER_COUNT) && (r_count_two <= LETTER_COUNT))
endmodule

### hdl/fsd_ram.sv
module fsd_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 26
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
